FILE: rtl/core/iorr_pkg.sv
// Shared types, codes and constants of the interrupt override redirection router.
package iorr_pkg;

	localparam int MAX_CONTROLLERS_DEF = 8;
	localparam int MAX_OVERRIDES_DEF   = 24;

	// Item kinds carried in the input tuser.
	localparam logic [1:0] FN_LOAD_OV   = 2'd0;
	localparam logic [1:0] FN_LOAD_CT   = 2'd1;
	localparam logic [1:0] FN_ROUTE_ISA = 2'd2;
	localparam logic [1:0] FN_ROUTE_GSI = 2'd3;

	// Result status codes carried in the output tuser.
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_NOCOV = 2'd2;

	localparam logic [1:0] FLAG_SET = 2'b11;
	localparam logic [7:0] REG_BASE = 8'h10;

	// Override entry: {mode[1:0], target[15:0], source[7:0]}.
	localparam int OV_W = 26;
	// Controller entry: {lines[8:0], base[15:0]}.
	localparam int CT_W = 25;

	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 88;

	typedef struct packed {
		logic accept;
		logic ov_wr;
		logic ct_wr;
		logic set_full;
		logic set_nocov;
		logic idx_clr;
		logic idx_inc;
		logic ov_take;
		logic ct_take;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic ov_full;
		logic ct_full;
		logic ov_empty;
		logic ct_empty;
		logic ov_last;
		logic ct_last;
		logic ov_hit;
		logic ct_hit;
		logic out_busy;
	} sts_t;

endpackage

FILE: rtl/core/iorr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module iorr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[raddr];
	end

	assign rdata = rd_data_q;

endmodule

FILE: rtl/core/iorr_ctrl.sv
// Controller state machine: sequences table loads and the override and controller scans.
module iorr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       in_func,
	output logic             in_ready,
	input  iorr_pkg::sts_t   sts,
	output iorr_pkg::cmd_t   cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_OV_RD  = 6'b000010,
		S_OV_CMP = 6'b000100,
		S_CT_RD  = 6'b001000,
		S_CT_CMP = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept  = 1'b1;
					cmd.idx_clr = 1'b1;
					case (in_func)
						iorr_pkg::FN_LOAD_OV: begin
							cmd.set_full = sts.ov_full;
							cmd.ov_wr    = !sts.ov_full;
							state_nx     = S_DONE;
						end
						iorr_pkg::FN_LOAD_CT: begin
							cmd.set_full = sts.ct_full;
							cmd.ct_wr    = !sts.ct_full;
							state_nx     = S_DONE;
						end
						iorr_pkg::FN_ROUTE_ISA: begin
							if (!sts.ov_empty) begin
								state_nx = S_OV_RD;
							end else if (sts.ct_empty) begin
								cmd.set_nocov = 1'b1;
								state_nx      = S_DONE;
							end else begin
								state_nx = S_CT_RD;
							end
						end
						default: begin
							if (sts.ct_empty) begin
								cmd.set_nocov = 1'b1;
								state_nx      = S_DONE;
							end else begin
								state_nx = S_CT_RD;
							end
						end
					endcase
				end
			end
			S_OV_RD: begin
				state_nx = S_OV_CMP;
			end
			S_OV_CMP: begin
				// The first matching override ends the scan; no match keeps the ISA line.
				if (sts.ov_hit || sts.ov_last) begin
					cmd.ov_take = sts.ov_hit;
					cmd.idx_clr = 1'b1;
					if (sts.ct_empty) begin
						cmd.set_nocov = 1'b1;
						state_nx      = S_DONE;
					end else begin
						state_nx = S_CT_RD;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					state_nx    = S_OV_RD;
				end
			end
			S_CT_RD: begin
				state_nx = S_CT_CMP;
			end
			S_CT_CMP: begin
				if (sts.ct_hit) begin
					cmd.ct_take = 1'b1;
					state_nx    = S_DONE;
				end else if (sts.ct_last) begin
					cmd.set_nocov = 1'b1;
					state_nx      = S_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nx    = S_CT_RD;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/iorr_dp.sv
// Datapath: table memories, counts, scan index, entry builder and output register.
module iorr_dp #(
	parameter int MAX_CONTROLLERS = iorr_pkg::MAX_CONTROLLERS_DEF,
	parameter int MAX_OVERRIDES   = iorr_pkg::MAX_OVERRIDES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  iorr_pkg::cmd_t  cmd,
	output iorr_pkg::sts_t  sts,
	input  logic [1:0]      in_func,
	input  logic [7:0]      in_isa_line,
	input  logic [15:0]     in_global_line,
	input  logic [15:0]     in_override_flags,
	input  logic [15:0]     in_line_base,
	input  logic [7:0]      in_max_entry,
	input  logic [7:0]      in_vector_num,
	input  logic [2:0]      in_deliver_mode,
	input  logic            in_low_active,
	input  logic            in_level_mode,
	input  logic [7:0]      in_dest_id,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [1:0]      out_status,
	output logic [2:0]      out_controller_slot,
	output logic [7:0]      out_pin_index,
	output logic [7:0]      out_reg_index,
	output logic [31:0]     out_entry_low,
	output logic [31:0]     out_entry_high
);

	localparam int OAW = (MAX_OVERRIDES > 1) ? $clog2(MAX_OVERRIDES) : 1;
	localparam int CAW = (MAX_CONTROLLERS > 1) ? $clog2(MAX_CONTROLLERS) : 1;
	localparam int OCW = $clog2(MAX_OVERRIDES + 1);
	localparam int CCW = $clog2(MAX_CONTROLLERS + 1);
	localparam int IW  = (OCW > CCW) ? OCW : CCW;
	localparam int OV_W_L = iorr_pkg::OV_W;
	localparam int CT_W_L = iorr_pkg::CT_W;

	logic [OCW-1:0] ov_cnt_q;
	logic [CCW-1:0] ct_cnt_q;
	logic [IW-1:0]  idx_q;
	logic [IW:0]    idx_nx;

	logic [7:0]  isa_q;
	logic [15:0] line_q;
	logic [7:0]  vec_q;
	logic [2:0]  dmode_q;
	logic        lo_q;
	logic        lvl_q;
	logic [7:0]  dest_q;

	logic [1:0]  res_status_q;
	logic [2:0]  res_slot_q;
	logic [7:0]  res_pin_q;
	logic [7:0]  res_reg_q;
	logic [31:0] res_low_q;
	logic [31:0] res_high_q;

	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [2:0]  out_slot_q;
	logic [7:0]  out_pin_q;
	logic [7:0]  out_reg_q;
	logic [31:0] out_low_q;
	logic [31:0] out_high_q;

	logic [OV_W_L-1:0] ov_wdata;
	logic [OV_W_L-1:0] ov_rdata;
	logic [CT_W_L-1:0] ct_wdata;
	logic [CT_W_L-1:0] ct_rdata;

	logic [1:0]  ov_mode_in;
	logic [15:0] ct_base;
	logic [8:0]  ct_lines;
	logic [16:0] ct_top;
	logic [15:0] pin_full;
	logic [7:0]  pin;
	logic [CAW+2:0] slot_ext;

	assign ov_mode_in[0] = (in_override_flags[1:0] == iorr_pkg::FLAG_SET);
	assign ov_mode_in[1] = (in_override_flags[3:2] == iorr_pkg::FLAG_SET);
	assign ov_wdata = {ov_mode_in, in_global_line, in_isa_line};
	assign ct_wdata = {9'(in_max_entry) + 9'd1, in_line_base};

	iorr_ram #(
		.WIDTH(OV_W_L),
		.DEPTH(MAX_OVERRIDES)
	) u_ov_ram (
		.clk   (clk),
		.we    (cmd.ov_wr),
		.waddr (ov_cnt_q[OAW-1:0]),
		.wdata (ov_wdata),
		.raddr (idx_q[OAW-1:0]),
		.rdata (ov_rdata)
	);

	iorr_ram #(
		.WIDTH(CT_W_L),
		.DEPTH(MAX_CONTROLLERS)
	) u_ct_ram (
		.clk   (clk),
		.we    (cmd.ct_wr),
		.waddr (ct_cnt_q[CAW-1:0]),
		.wdata (ct_wdata),
		.raddr (idx_q[CAW-1:0]),
		.rdata (ct_rdata)
	);

	assign ct_base  = ct_rdata[15:0];
	assign ct_lines = ct_rdata[24:16];
	assign ct_top   = {1'b0, ct_base} + {8'b0, ct_lines};
	assign pin_full = line_q - ct_base;
	assign pin      = pin_full[7:0];
	assign slot_ext = {3'b0, idx_q[CAW-1:0]};
	assign idx_nx   = {1'b0, idx_q} + (IW+1)'(1);

	assign sts.ov_full  = (ov_cnt_q == OCW'(MAX_OVERRIDES));
	assign sts.ct_full  = (ct_cnt_q == CCW'(MAX_CONTROLLERS));
	assign sts.ov_empty = (ov_cnt_q == '0);
	assign sts.ct_empty = (ct_cnt_q == '0);
	assign sts.ov_last  = (idx_nx == (IW+1)'(ov_cnt_q));
	assign sts.ct_last  = (idx_nx == (IW+1)'(ct_cnt_q));
	assign sts.ov_hit   = (ov_rdata[7:0] == isa_q);
	assign sts.ct_hit   = ({1'b0, line_q} >= {1'b0, ct_base}) && ({1'b0, line_q} < ct_top);
	assign sts.out_busy = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_cnt_q    <= '0;
			ct_cnt_q    <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ov_wr) begin
				ov_cnt_q <= ov_cnt_q + OCW'(1);
			end
			if (cmd.ct_wr) begin
				ct_cnt_q <= ct_cnt_q + CCW'(1);
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_nx[IW-1:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			isa_q   <= in_isa_line;
			vec_q   <= in_vector_num;
			dest_q  <= in_dest_id;
			// An ISA route starts on the ISA line itself, fixed delivery, high and edge.
			if (in_func == iorr_pkg::FN_ROUTE_GSI) begin
				line_q  <= in_global_line;
				dmode_q <= in_deliver_mode;
				lo_q    <= in_low_active;
				lvl_q   <= in_level_mode;
			end else begin
				line_q  <= {8'b0, in_isa_line};
				dmode_q <= 3'b0;
				lo_q    <= 1'b0;
				lvl_q   <= 1'b0;
			end
			res_status_q <= cmd.set_full ? iorr_pkg::ST_FULL :
				(cmd.set_nocov ? iorr_pkg::ST_NOCOV : iorr_pkg::ST_DONE);
			res_slot_q   <= '0;
			res_pin_q    <= '0;
			res_reg_q    <= '0;
			res_low_q    <= '0;
			res_high_q   <= '0;
		end
		if (cmd.ov_take) begin
			line_q <= ov_rdata[23:8];
			lo_q   <= ov_rdata[24];
			lvl_q  <= ov_rdata[25];
		end
		if (cmd.set_nocov && !cmd.accept) begin
			res_status_q <= iorr_pkg::ST_NOCOV;
		end
		if (cmd.ct_take) begin
			res_slot_q <= slot_ext[2:0];
			res_pin_q  <= pin;
			res_reg_q  <= iorr_pkg::REG_BASE + {pin[6:0], 1'b0};
			res_low_q  <= {16'b0, lvl_q, 1'b0, lo_q, 2'b0, dmode_q, vec_q};
			res_high_q <= {dest_q, 24'b0};
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_pin_q    <= res_pin_q;
			out_reg_q    <= res_reg_q;
			out_low_q    <= res_low_q;
			out_high_q   <= res_high_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign out_status          = out_status_q;
	assign out_controller_slot = out_slot_q;
	assign out_pin_index       = out_pin_q;
	assign out_reg_index       = out_reg_q;
	assign out_entry_low       = out_low_q;
	assign out_entry_high      = out_high_q;

endmodule

FILE: rtl/core/irq_override_redirection_router.sv
// Top level of the ISA override and IOAPIC redirection entry router.
//
// Input items arrive on the s_ stream. s_tuser selects the kind: load an ISA override,
// load a controller, route an ISA line or route a global line. Each item gives exactly
// one result item on the m_ stream, with its status in m_tuser and the controller slot,
// pin, register index and the two redirection entry words in m_tdata.
// Items are handled one at a time. A load goes from acceptance through the done state to
// the result register. A global route scans the controller entries in turn, at most the
// controller count, before the done state. An ISA route first scans the override entries,
// up to the first match or the last entry, before the controller scan. The tables sit in
// single-write, single-read registered-read memories, so each examined entry takes a read
// state and then a compare state in the scan state machine.
// The result sits in an output register; a new item is accepted as soon as the scan of
// the previous one is done, even while its result still waits for m_tready. A stalled
// receiver holds the block only when the next result is ready to be written out.
// Reset empties both tables and drops any pending result; table contents need no clearing.
module irq_override_redirection_router #(
	parameter int MAX_CONTROLLERS = iorr_pkg::MAX_CONTROLLERS_DEF,
	parameter int MAX_OVERRIDES   = iorr_pkg::MAX_OVERRIDES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// isa_line, global_line, override_flags, line_base, max_entry, vector_num,
	// deliver_mode, low_active, level_mode, dest_id, zero pad
	input  logic [iorr_pkg::IN_TDATA_W-1:0]    s_tdata,
	// func
	input  logic [1:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// controller_slot, pin_index, reg_index, entry_low, entry_high, zero pad
	output logic [iorr_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// status
	output logic [1:0]                         m_tuser
);

	iorr_pkg::cmd_t cmd;
	iorr_pkg::sts_t sts;

	logic [2:0]  res_slot;
	logic [7:0]  res_pin;
	logic [7:0]  res_reg;
	logic [31:0] res_low;
	logic [31:0] res_high;

	iorr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_func  (s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	iorr_dp #(
		.MAX_CONTROLLERS (MAX_CONTROLLERS),
		.MAX_OVERRIDES   (MAX_OVERRIDES)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.in_func             (s_tuser),
		.in_isa_line         (s_tdata[7:0]),
		.in_global_line      (s_tdata[23:8]),
		.in_override_flags   (s_tdata[39:24]),
		.in_line_base        (s_tdata[55:40]),
		.in_max_entry        (s_tdata[63:56]),
		.in_vector_num       (s_tdata[71:64]),
		.in_deliver_mode     (s_tdata[74:72]),
		.in_low_active       (s_tdata[75]),
		.in_level_mode       (s_tdata[76]),
		.in_dest_id          (s_tdata[84:77]),
		.out_valid           (m_tvalid),
		.out_ready           (m_tready),
		.out_status          (m_tuser),
		.out_controller_slot (res_slot),
		.out_pin_index       (res_pin),
		.out_reg_index       (res_reg),
		.out_entry_low       (res_low),
		.out_entry_high      (res_high)
	);

	assign m_tdata = {5'b0, res_high, res_low, res_reg, res_pin, res_slot};

`ifndef SYNTH
	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is still in progress");

	a_status_code_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == iorr_pkg::ST_DONE || m_tuser == iorr_pkg::ST_FULL ||
			m_tuser == iorr_pkg::ST_NOCOV))
		else $error("result carries an undefined status code");

	a_error_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != iorr_pkg::ST_DONE |-> m_tdata == '0)
		else $error("failed item returned nonzero route fields");

	a_reg_index_follows_pin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[18:11] != 8'h00 |->
			m_tdata[18:11] == iorr_pkg::REG_BASE + {m_tdata[9:3], 1'b0})
		else $error("register index does not match the pin");
`endif

endmodule
